FILE: sv/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants for the permutation rank encoder
// Holds the fixed rank code width and the control word handed from the
// compare stage to the fold stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pre_pkg;

	localparam int CODE_W = 22;

	// control bits of one element leaving the compare stage
	typedef struct packed {
		logic fold;     // element was stored and is not the first one
		logic last;     // element closes the sequence
		logic dropped;  // element arrived past the maximum length
	} pre_ctrl_t;

endpackage

FILE: sv/pre_ifs.sv
// ----------------------------------------------------------------------------
// pre_ifs: stream interfaces of the permutation rank encoder
// Element words in, rank words out; valid/ready handshake on both.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pre_elem_if #(
	parameter int ELEMENT_BITS = 4
);
	logic                    valid;
	logic                    ready;
	logic [ELEMENT_BITS-1:0] element;
	logic                    last;

	modport source (output valid, output element, output last, input ready);
	modport sink (input valid, input element, input last, output ready);
endinterface

interface pre_rank_if import pre_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] rank_code;
	logic              too_long;

	modport source (output valid, output rank_code, output too_long, input ready);
	modport sink (input valid, input rank_code, input too_long, output ready);
endinterface

FILE: sv/permutation_rank_encoder.sv
// ----------------------------------------------------------------------------
// permutation_rank_encoder: Lehmer code rank of an element sequence
// Takes one element word per cycle unless stalled; the word with last set
// closes the sequence and yields one rank word: the inversion counts of
// all elements folded in mixed radix (code = code * (position + 1) + count),
// plus a too_long flag when more than MAX_ELEMENTS elements arrived (extra
// elements are dropped). Earlier elements sit in a shift chain of compare
// cells, so every stored element is checked against the new one in the same
// cycle: one element word per clock while the element side is not stalled.
// The last element passes two register stages (compare/count stage, then the
// fold multiplier stage into the output register) before its rank word is
// valid. Back-pressure on the rank side stalls the element side only when
// both stages are full. The code wraps at 22 bits when MAX_ELEMENTS is
// above 10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_rank_encoder import pre_pkg::*; #(
	parameter int MAX_ELEMENTS = 10,
	parameter int ELEMENT_BITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pre_elem_if.sink   elements,
	pre_rank_if.source ranks
);

	// position, count and a stored element's multiplier stay within 0..MAX_ELEMENTS
	localparam int PW = $clog2(MAX_ELEMENTS + 1);

	logic [PW-1:0]           pos_q;
	logic                    accept;
	logic                    store;
	logic                    take;

	// cell chain: cell 0 holds the newest element
	logic [ELEMENT_BITS-1:0] elem_w [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] greater_w;
	logic [PW-1:0]           count;

	// compare stage registers
	logic                    s1_valid_q;
	pre_ctrl_t               ctrl_s1;
	logic [PW-1:0]           cnt_s1;
	logic [PW-1:0]           mult_s1;

	assign elements.ready = !s1_valid_q || take;
	assign accept         = elements.valid && elements.ready;
	// past the maximum length the element is dropped
	assign store          = accept && (pos_q != PW'(MAX_ELEMENTS));

	genvar k;
	generate
		for (k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
			if (k == 0) begin : g_head
				pre_cell #(.ELEMENT_BITS(ELEMENT_BITS)) u_cell (
					.clk       (clk),
					.shift_en  (store),
					.cell_valid(pos_q > PW'(k)),
					.prev_elem (elements.element),
					.probe     (elements.element),
					.elem      (elem_w[k]),
					.greater   (greater_w[k])
				);
			end else begin : g_body
				pre_cell #(.ELEMENT_BITS(ELEMENT_BITS)) u_cell (
					.clk       (clk),
					.shift_en  (store),
					.cell_valid(pos_q > PW'(k)),
					.prev_elem (elem_w[k-1]),
					.probe     (elements.element),
					.elem      (elem_w[k]),
					.greater   (greater_w[k])
				);
			end
		end
	endgenerate

	// number of earlier elements greater than the new one
	always_comb begin
		count = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			count = count + PW'(greater_w[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (elements.last) begin
					pos_q <= '0;
				end else if (store) begin
					pos_q <= pos_q + PW'(1);
				end
				s1_valid_q <= 1'b1;
			end else if (take) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1.fold    <= store && (pos_q != '0);
			ctrl_s1.last    <= elements.last;
			ctrl_s1.dropped <= !store;
			cnt_s1          <= count;
			mult_s1         <= pos_q + PW'(1);
		end
	end

	pre_fold #(.CNT_W(PW)) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_valid(s1_valid_q),
		.ctrl    (ctrl_s1),
		.cnt     (cnt_s1),
		.mult    (mult_s1),
		.take    (take),
		.ranks   (ranks)
	);

endmodule

FILE: sv/pre_cell.sv
// ----------------------------------------------------------------------------
// pre_cell: one storage and compare cell of the element chain
// Holds one earlier element, takes its neighbor's element on a shift, and
// flags when it is greater than the element being ranked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pre_cell #(
	parameter int ELEMENT_BITS = 4
) (
	input  logic                    clk,
	input  logic                    shift_en,
	input  logic                    cell_valid,
	input  logic [ELEMENT_BITS-1:0] prev_elem,
	input  logic [ELEMENT_BITS-1:0] probe,
	output logic [ELEMENT_BITS-1:0] elem,
	output logic                    greater
);

	logic [ELEMENT_BITS-1:0] elem_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (shift_en) begin
			elem_q <= prev_elem;
		end
	end

	assign elem    = elem_q;
	assign greater = cell_valid && (elem_q > probe);

endmodule

FILE: sv/pre_fold.sv
// ----------------------------------------------------------------------------
// pre_fold: mixed-radix fold and output register
// Folds each inversion count into the running code and holds the finished
// rank word until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pre_fold import pre_pkg::*; #(
	parameter int CNT_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  pre_ctrl_t        ctrl,
	input  logic [CNT_W-1:0] cnt,
	input  logic [CNT_W-1:0] mult,
	output logic             take,
	pre_rank_if.source       ranks
);

	localparam int PROD_W = CODE_W + CNT_W;

	logic [CODE_W-1:0] code_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic              out_ovf_q;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;
	logic [CODE_W-1:0] next_code;
	logic              next_ovf;

	assign take = s1_valid && (!out_valid_q || ranks.ready);

	// code * (position + 1) + count, wraps at the code width
	assign prod      = {{CNT_W{1'b0}}, code_q} * {{CODE_W{1'b0}}, mult};
	assign sum       = prod + {{CODE_W{1'b0}}, cnt};
	assign next_code = ctrl.fold ? sum[CODE_W-1:0] : code_q;
	assign next_ovf  = ovf_q | ctrl.dropped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (ctrl.last) begin
					code_q      <= '0;
					ovf_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					code_q <= next_code;
					ovf_q  <= next_ovf;
					if (ranks.ready) begin
						out_valid_q <= 1'b0;
					end
				end
			end else if (ranks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctrl.last) begin
			out_code_q <= next_code;
			out_ovf_q  <= next_ovf;
		end
	end

	assign ranks.valid     = out_valid_q;
	assign ranks.rank_code = out_code_q;
	assign ranks.too_long  = out_ovf_q;

endmodule

FILE: dv/permutation_rank_encoder_test.sv
// ----------------------------------------------------------------------------
// permutation_rank_encoder_test: self-checking bench for the rank encoder
// Feeds element sequences (directed corner sequences, then random ones of
// legal and excess length) through the element stream. An internal Lehmer
// fold predicts every rank word, and the rank stream is checked in order.
// Both streams idle at random, and the rank side holds off once for a long
// stretch so the pipe fills and back-pressures the element side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_rank_encoder_test import pre_pkg::*; ;

	localparam int MAX_LEN = 10;
	localparam int ELEM_W  = 4;
	localparam int TOTAL_WORDS = 1350;
	localparam int HOLD_AT = 400;     // element words taken before the long hold
	localparam int HOLD_CYCLES = 80;

	// one element word as queued for the driver
	typedef struct {
		logic [ELEM_W-1:0] element;
		logic              last;
	} elem_word_t;

	// one rank word as predicted
	typedef struct {
		logic [CODE_W-1:0] rank_code;
		logic              too_long;
	} rank_word_t;

	logic clk;
	logic arst_n;

	pre_elem_if #(.ELEMENT_BITS(ELEM_W)) elements ();
	pre_rank_if ranks ();

	permutation_rank_encoder #(
		.MAX_ELEMENTS(MAX_LEN),
		.ELEMENT_BITS(ELEM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.elements(elements),
		.ranks(ranks)
	);

	elem_word_t  pending_words[$];
	rank_word_t  expected_ranks[$];
	int unsigned words_queued = 0;
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned fail_cnt = 0;

	// handshakes seen at the last rising edge, used by the falling-edge drivers
	bit elem_fire = 0;
	bit rank_fire = 0;

	// predictor state: stored elements, fill position, partial code, drop flag
	logic [ELEM_W-1:0] seen_elems[MAX_LEN];
	int unsigned       seq_pos = 0;
	logic [CODE_W-1:0] fold_code = '0;
	logic              dropped_any = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap lengths: mostly none or short, now and then long.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Fold one accepted element into the predicted code. Only entries below
	// the fill position are compared, so unwritten store slots are never read.
	task automatic lehmer_step(input logic [ELEM_W-1:0] value, input logic is_last);
		int unsigned greater;
		int unsigned wide;
		rank_word_t  done;
		if (seq_pos < MAX_LEN) begin
			if (seq_pos > 0) begin
				greater = 0;
				for (int k = 0; k < seq_pos; k++)
					if (seen_elems[k] > value)
						greater++;
				// code * (pos + 1) + count, wrapped to the code width
				wide = fold_code * (seq_pos + 1) + greater;
				fold_code = wide[CODE_W-1:0];
			end
			seen_elems[seq_pos] = value;
			seq_pos++;
		end else begin
			// past the maximum length: word is dropped, flag sticks until last
			dropped_any = 1'b1;
		end
		if (is_last) begin
			done.rank_code = fold_code;
			done.too_long = dropped_any;
			expected_ranks.push_back(done);
			seq_pos = 0;
			fold_code = '0;
			dropped_any = 1'b0;
		end
	endtask

	task automatic queue_word(input logic [ELEM_W-1:0] value, input logic is_last);
		elem_word_t w;
		w.element = value;
		w.last = is_last;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Random sequence of n elements; narrow values give many equal elements.
	task automatic queue_sequence(input int unsigned n, input bit narrow);
		for (int unsigned i = 0; i < n; i++)
			queue_word(narrow ? ELEM_W'($urandom_range(0, 3)) : ELEM_W'($urandom_range(0, 15)),
				i == n - 1);
	endtask

	// Monitor: both handshakes are sampled here at the rising edge.
	always @(posedge clk) begin
		rank_word_t want;
		elem_fire = arst_n && elements.valid && elements.ready;
		rank_fire = arst_n && ranks.valid && ranks.ready;
		if (elem_fire) begin
			lehmer_step(elements.element, elements.last);
			words_in++;
		end
		if (rank_fire) begin
			words_out++;
			if (expected_ranks.size() == 0) begin
				$error("rank word with no sequence closed: rank_code %0d too_long %0b",
					ranks.rank_code, ranks.too_long);
				fail_cnt++;
			end else begin
				want = expected_ranks.pop_front();
				if (ranks.rank_code !== want.rank_code) begin
					$error("rank_code: expected %0d, got %0d", want.rank_code, ranks.rank_code);
					fail_cnt++;
				end
				if (ranks.too_long !== want.too_long) begin
					$error("too_long: expected %0b, got %0b", want.too_long, ranks.too_long);
					fail_cnt++;
				end
			end
		end
	end

	// Element driver: moves on after each taken word, with random gaps.
	// Calm stretches (no gaps) come every fourth block of 150 words.
	int unsigned elem_gap = 0;
	always @(negedge clk) begin
		elem_word_t w;
		if (!arst_n) begin
			elements.valid <= 1'b0;
		end else if (elem_fire || !elements.valid) begin
			if (elem_fire)
				elem_gap = pick_gap(((words_in / 150) % 4) == 3);
			if (elem_gap > 0) begin
				elem_gap--;
				elements.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				elements.valid <= 1'b1;
				elements.element <= w.element;
				elements.last <= w.last;
			end else begin
				elements.valid <= 1'b0;
			end
		end
	end

	// Rank side ready: random stalls after each taken word, calm stretches,
	// and one long hold while elements keep coming so the pipe backs up.
	int unsigned rank_gap = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			ranks.ready <= 1'b0;
		end else begin
			if (rank_fire)
				rank_gap = pick_gap(((words_out / 30) % 4) == 1);
			if (!hold_done && words_in >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				ranks.ready <= 1'b0;
			end else if (rank_gap > 0) begin
				rank_gap--;
				ranks.ready <= 1'b0;
			end else begin
				ranks.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned len;
		elements.valid = 1'b0;
		elements.element = '0;
		elements.last = 1'b0;
		ranks.ready = 1'b0;
		arst_n = 1'b0;

		// single element: code is zero
		queue_word(4'd0, 1'b1);
		// strictly descending, full length: every earlier element is greater,
		// giving the largest code (10! - 1)
		for (int i = 0; i < MAX_LEN; i++)
			queue_word(4'(15 - i), i == MAX_LEN - 1);
		// ascending pair at the value extremes
		queue_word(4'd0, 1'b0);
		queue_word(4'd15, 1'b1);
		// equal elements never count
		queue_word(4'd7, 1'b0);
		queue_word(4'd7, 1'b1);
		// one past the maximum length, last word itself dropped: too_long set
		for (int i = 0; i <= MAX_LEN; i++)
			queue_word(ELEM_W'($urandom_range(0, 15)), i == MAX_LEN);

		// random sequences: mostly legal lengths, some overlong
		while (words_queued < TOTAL_WORDS) begin
			if ($urandom_range(0, 99) < 85)
				len = $urandom_range(1, MAX_LEN);
			else
				len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
			queue_sequence(len, $urandom_range(0, 3) == 0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all element words taken, then every rank word back, then drain time
		while (pending_words.size() != 0 || elements.valid)
			@(posedge clk);
		while (expected_ranks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
sv/pre_pkg.sv
sv/pre_ifs.sv
sv/pre_cell.sv
sv/pre_fold.sv
sv/permutation_rank_encoder.sv
dv/permutation_rank_encoder_test.sv
